// ===== src/kuz_pkg.sv =====
`timescale 1ns / 1ps
package kuz_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_AW      = $clog2(ROUND_COUNT);
    localparam int NUM_KSTEP   = 32;
    localparam int KSTEP_W     = $clog2(NUM_KSTEP);
    localparam int CFG_AW      = 3;

    // key register indexes
    localparam logic [CFG_AW-1:0] REG_KEY0 = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY1 = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KEY2 = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KEY3 = 3'd3;

    // block as bytes, byte 0 most significant
    typedef logic [0:15][7:0] t_blk;
    typedef logic [0:15][0:15][7:0] t_mat;
    typedef logic [0:NUM_KSTEP-1][127:0] t_cset;

    localparam logic [7:0] SBOX [256] = '{
        252, 238, 221, 17, 207, 110, 49, 22, 251, 196, 250, 218, 35, 197, 4, 77,
        233, 119, 240, 219, 147, 46, 153, 186, 23, 54, 241, 187, 20, 205, 95, 193,
        249, 24, 101, 90, 226, 92, 239, 33, 129, 28, 60, 66, 139, 1, 142, 79,
        5, 132, 2, 174, 227, 106, 143, 160, 6, 11, 237, 152, 127, 212, 211, 31,
        235, 52, 44, 81, 234, 200, 72, 171, 242, 42, 104, 162, 253, 58, 206, 204,
        181, 112, 14, 86, 8, 12, 118, 18, 191, 114, 19, 71, 156, 183, 93, 135,
        21, 161, 150, 41, 16, 123, 154, 199, 243, 145, 120, 111, 157, 158, 178, 177,
        50, 117, 25, 61, 255, 53, 138, 126, 109, 84, 198, 128, 195, 189, 13, 87,
        223, 245, 36, 169, 62, 168, 67, 201, 215, 121, 214, 246, 124, 34, 185, 3,
        224, 15, 236, 222, 122, 148, 176, 188, 220, 232, 40, 80, 78, 51, 10, 74,
        167, 151, 96, 115, 30, 0, 98, 68, 26, 184, 56, 130, 100, 159, 38, 65,
        173, 69, 70, 146, 39, 94, 85, 47, 140, 163, 165, 125, 105, 213, 149, 59,
        7, 88, 179, 64, 134, 172, 29, 247, 48, 55, 107, 228, 136, 217, 231, 137,
        225, 27, 131, 73, 76, 63, 248, 254, 141, 83, 170, 144, 202, 216, 133, 97,
        32, 113, 103, 164, 45, 43, 9, 91, 203, 155, 37, 208, 190, 229, 108, 82,
        89, 166, 116, 210, 230, 244, 180, 192, 209, 102, 175, 194, 57, 75, 99, 182
    };

    localparam logic [7:0] LIN_COEF [16] = '{
        148, 32, 133, 16, 194, 192, 1, 251, 1, 192, 194, 16, 133, 32, 148, 1
    };

    // GF(2^8) multiply, polynomial x^8+x^7+x^6+x+1
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] aa;
        acc = '0;
        aa  = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ aa;
            aa = aa[7] ? ({aa[6:0], 1'b0} ^ 8'hC3) : {aa[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [7:0] lin_sum(input t_blk b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++) acc = acc ^ gf_mul(b[i], LIN_COEF[i]);
        return acc;
    endfunction

    // full 16-step linear map, used only to build constant matrices
    function automatic t_blk lin_ref(input t_blk b, input logic inv);
        t_blk v;
        logic [7:0] t;
        v = b;
        for (int n = 0; n < 16; n++) begin
            if (!inv) begin
                t = lin_sum(v);
                for (int i = 15; i > 0; i--) v[i] = v[i-1];
                v[0] = t;
            end else begin
                t = v[0];
                for (int i = 0; i < 15; i++) v[i] = v[i+1];
                v[15] = t;
                v[15] = lin_sum(v);
            end
        end
        return v;
    endfunction

    function automatic t_mat mk_mat(input logic inv);
        t_mat m;
        t_blk e;
        t_blk c;
        for (int j = 0; j < 16; j++) begin
            e    = '0;
            e[j] = 8'd1;
            c    = lin_ref(e, inv);
            for (int i = 0; i < 16; i++) m[i][j] = c[i];
        end
        return m;
    endfunction

    localparam t_mat L_MAT    = mk_mat(1'b0);
    localparam t_mat LINV_MAT = mk_mat(1'b1);

    // matrix form of the linear map: each output byte is a sum of constant products
    function automatic t_blk lin_apply(input t_blk x, input t_mat m);
        t_blk y;
        for (int i = 0; i < 16; i++) begin
            y[i] = '0;
            for (int j = 0; j < 16; j++) y[i] = y[i] ^ gf_mul(x[j], m[i][j]);
        end
        return y;
    endfunction

    function automatic t_mat mk_sinv();
        t_mat s;
        for (int i = 0; i < 256; i++) s[SBOX[i][7:4]][SBOX[i][3:0]] = 8'(i);
        return s;
    endfunction

    localparam t_mat SBOX_INV = mk_sinv();

    function automatic t_cset mk_consts();
        t_cset c;
        t_blk v;
        for (int k = 0; k < NUM_KSTEP; k++) begin
            v     = '0;
            v[15] = 8'(k + 1);
            c[k]  = lin_apply(v, L_MAT);
        end
        return c;
    endfunction

    localparam t_cset KCONST = mk_consts();

    function automatic t_blk sub_fwd(input t_blk x);
        t_blk y;
        for (int i = 0; i < 16; i++) y[i] = SBOX[x[i]];
        return y;
    endfunction

    function automatic t_blk sub_back(input t_blk x);
        t_blk y;
        for (int i = 0; i < 16; i++) y[i] = SBOX_INV[x[i][7:4]][x[i][3:0]];
        return y;
    endfunction

endpackage

// ===== src/kuz_ram.sv =====
`timescale 1ns / 1ps
module kuz_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/kuznyechik_block_cipher.sv =====
`timescale 1ns / 1ps
// channel     | dir | beat contents
// s_axis      | in  | tdata: block_high, block_low; tuser: action
// m_axis      | out | tdata: result_high, result_low
// i_cfg_*     | in  | key word write, index 0..3
// A block goes from accept to result through one round key fetch, ten rounds
// through one shared round unit reading a round key memory each cycle, and one
// output load; the next block is taken only after that output load.
// Reset and every key write start the key schedule (one key load, 32 Feistel
// steps and 10 round key writes) with s_axis_tready low.
// A result waits in the output register; the next block is taken meanwhile.
// The output load stalls while the output register still holds an unread beat.
module kuznyechik_block_cipher (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kuz_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [63:0]                 i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [127:0]                s_axis_tdata,  // block_high, block_low
    input  logic [0:0]                  s_axis_tuser,  // action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [127:0]                m_axis_tdata   // result_high, result_low
);
    import kuz_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_KINIT = 3'd4;
    localparam logic [2:0] S_KWR   = 3'd5;
    localparam logic [2:0] S_KSTEP = 3'd6;

    localparam logic [KEY_AW-1:0] LAST = KEY_AW'(ROUND_COUNT - 1);

    logic [2:0]         r_state;
    logic [63:0]        r_key [4];
    logic [KEY_AW-1:0]  r_cnt;
    logic [KEY_AW-1:0]  r_ki;
    logic               r_sel;
    logic [KSTEP_W-1:0] r_kstep;
    logic               r_dec;
    t_blk               r_x;
    t_blk               r_a1;
    t_blk               r_a0;
    logic [127:0]       r_out;
    logic               r_ovalid;

    logic [KEY_AW-1:0]  step;
    logic [KEY_AW-1:0]  enc_raddr;
    logic [KEY_AW-1:0]  dec_raddr;
    logic [127:0]       enc_rdata;
    logic [127:0]       dec_rdata;
    logic               kwe;
    logic [KEY_AW-1:0]  kwaddr;
    t_blk               kwblk;
    t_blk               n_x;
    t_blk               n_a1;
    logic               key_hit;

    // round key memories: forward keys and inverse-linear keys
    assign step      = (r_state == S_RUN && r_cnt != LAST) ? r_cnt + 1'b1 : '0;
    assign enc_raddr = r_dec ? '0 : step;
    assign dec_raddr = LAST - step;
    assign kwe       = (r_state == S_KWR);
    assign kwaddr    = r_ki + KEY_AW'(r_sel);
    assign kwblk     = r_sel ? r_a0 : r_a1;

    kuz_ram #(.WIDTH(128), .DEPTH(ROUND_COUNT)) u_enc_ram (
        .i_clk  (i_clk),
        .i_we   (kwe),
        .i_waddr(kwaddr),
        .i_wdata(kwblk),
        .i_raddr(enc_raddr),
        .o_rdata(enc_rdata)
    );

    kuz_ram #(.WIDTH(128), .DEPTH(ROUND_COUNT)) u_dec_ram (
        .i_clk  (i_clk),
        .i_we   (kwe),
        .i_waddr(kwaddr),
        .i_wdata(lin_apply(kwblk, LINV_MAT)),
        .i_raddr(dec_raddr),
        .o_rdata(dec_rdata)
    );

    // one round per cycle
    always_comb begin
        if (!r_dec) begin
            if (r_cnt == LAST) n_x = r_x ^ enc_rdata;
            else               n_x = lin_apply(sub_fwd(r_x ^ enc_rdata), L_MAT);
        end else begin
            if (r_cnt == LAST)   n_x = sub_back(r_x) ^ enc_rdata;
            else if (r_cnt == 0) n_x = lin_apply(r_x, LINV_MAT) ^ dec_rdata;
            else                 n_x = lin_apply(sub_back(r_x), LINV_MAT) ^ dec_rdata;
        end
    end

    // one Feistel step of the key schedule
    assign n_a1 = lin_apply(sub_fwd(r_a1 ^ KCONST[r_kstep]), L_MAT) ^ r_a0;

    assign key_hit = (i_cfg_addr == REG_KEY0) || (i_cfg_addr == REG_KEY1) ||
                     (i_cfg_addr == REG_KEY2) || (i_cfg_addr == REG_KEY3);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_out[63:0], r_out[127:64]};

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KEY0: r_key[0] <= i_cfg_wdata;
                REG_KEY1: r_key[1] <= i_cfg_wdata;
                REG_KEY2: r_key[2] <= i_cfg_wdata;
                REG_KEY3: r_key[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) r_out <= r_x;
    end

    // sequencer: block rounds and key schedule
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KINIT;
            r_cnt   <= '0;
            r_ki    <= '0;
            r_sel   <= 1'b0;
            r_kstep <= '0;
            r_dec   <= 1'b0;
        end else if (i_cfg_we && key_hit) begin
            r_state <= S_KINIT;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_x     <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
                        r_dec   <= s_axis_tuser[0];
                        r_cnt   <= '0;
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_RUN;
                S_RUN: begin
                    r_x   <= n_x;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) r_state <= S_IDLE;
                end
                S_KINIT: begin
                    r_a1    <= {r_key[0], r_key[1]};
                    r_a0    <= {r_key[2], r_key[3]};
                    r_ki    <= '0;
                    r_sel   <= 1'b0;
                    r_kstep <= '0;
                    r_dec   <= 1'b0;
                    r_state <= S_KWR;
                end
                S_KWR: begin
                    r_sel <= ~r_sel;
                    if (r_sel) begin
                        r_ki    <= r_ki + KEY_AW'(2);
                        r_state <= (r_ki == LAST - 1'b1) ? S_IDLE : S_KSTEP;
                    end
                end
                S_KSTEP: begin
                    r_a1    <= n_a1;
                    r_a0    <= r_a1;
                    r_kstep <= r_kstep + 1'b1;
                    if (r_kstep[2:0] == 3'd7) r_state <= S_KWR;
                end
                default: r_state <= S_KINIT;
            endcase
        end
    end
endmodule

// ===== dv/kuz_result_checker.sv =====
`timescale 1ns / 1ps
module kuz_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kuz_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [63:0]                 i_cfg_wdata,
    input  logic                        i_blk_valid,
    input  logic                        i_blk_ready,
    input  logic [127:0]                i_blk_data,
    input  logic [0:0]                  i_blk_action,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [127:0]                i_res_data,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked
);
    import kuz_pkg::*;

    typedef logic [0:15][7:0] bytes_t;

    localparam logic [7:0] POLY_TAPS = 8'hC3;
    localparam logic       ACT_ENC   = 1'b0;

    logic [7:0]  sb [256];
    logic [7:0]  sb_inv [256];
    logic [7:0]  mix_coef [16];
    logic [63:0] key_reg [4];
    bytes_t      enc_rk [10];
    bytes_t      dec_rk [10];
    logic [127:0] cipher_expect_q [$];

    function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = a[7] ? ({a[6:0], 1'b0} ^ POLY_TAPS) : {a[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [7:0] mix_sum(bytes_t b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 16; i++) acc ^= field_mul(b[i], mix_coef[i]);
        return acc;
    endfunction

    function automatic bytes_t mix_fwd(bytes_t b);
        logic [7:0] t;
        for (int n = 0; n < 16; n++) begin
            t = mix_sum(b);
            for (int i = 15; i > 0; i--) b[i] = b[i-1];
            b[0] = t;
        end
        return b;
    endfunction

    function automatic bytes_t mix_back(bytes_t b);
        logic [7:0] t;
        for (int n = 0; n < 16; n++) begin
            t = b[0];
            for (int i = 0; i < 15; i++) b[i] = b[i+1];
            b[15] = t;
            b[15] = mix_sum(b);
        end
        return b;
    endfunction

    function automatic bytes_t subst(bytes_t b, logic inv);
        for (int i = 0; i < 16; i++) b[i] = inv ? sb_inv[b[i]] : sb[b[i]];
        return b;
    endfunction

    // Feistel schedule over 32 constants
    task automatic schedule_keys();
        bytes_t a1, a0, t, c;
        enc_rk[0] = {key_reg[0], key_reg[1]};
        enc_rk[1] = {key_reg[2], key_reg[3]};
        for (int p = 0; p < 4; p++) begin
            a1 = enc_rk[2*p];
            a0 = enc_rk[2*p+1];
            for (int j = 0; j < 8; j++) begin
                c = '0;
                c[15] = 8'(8*p + j + 1);
                t = mix_fwd(subst(a1 ^ mix_fwd(c), 1'b0)) ^ a0;
                a0 = a1;
                a1 = t;
            end
            enc_rk[2*p+2] = a1;
            enc_rk[2*p+3] = a0;
        end
        for (int r = 0; r < 10; r++) dec_rk[r] = mix_back(enc_rk[r]);
    endtask

    // x holds byte 0 in the top bits: block_high above block_low
    function automatic logic [127:0] cipher_block(logic act, bytes_t x);
        if (act == ACT_ENC) begin
            for (int r = 0; r < 9; r++) x = mix_fwd(subst(x ^ enc_rk[r], 1'b0));
            x ^= enc_rk[9];
        end else begin
            x = subst(x, 1'b0);
            for (int r = 9; r >= 1; r--) x = mix_back(subst(x, 1'b1)) ^ dec_rk[r];
            x = subst(x, 1'b1) ^ enc_rk[0];
        end
        return x;
    endfunction

    task automatic report(string what, logic [127:0] got, logic [127:0] want);
        $display("[%0t] %s: got %h want %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
        for (int i = 0; i < 256; i++) begin
            sb[i] = SBOX[i];
            sb_inv[SBOX[i]] = 8'(i);
        end
        for (int i = 0; i < 16; i++) mix_coef[i] = LIN_COEF[i];
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        schedule_keys();
    end

    assign o_pending = cipher_expect_q.size();

    always @(posedge i_clk) begin
        logic [127:0] want;
        logic [127:0] blk;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) key_reg[i] = '0;
            schedule_keys();
            cipher_expect_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_addr <= REG_KEY3) begin
                key_reg[i_cfg_addr] = i_cfg_wdata;
                schedule_keys();
            end
            // tdata carries the high word in its low half; queue in beat layout
            if (i_blk_valid && i_blk_ready) begin
                blk = cipher_block(i_blk_action[0],
                                   {i_blk_data[63:0], i_blk_data[127:64]});
                cipher_expect_q.push_back({blk[63:0], blk[127:64]});
            end
            if (i_res_valid && i_res_ready) begin
                o_checked++;
                if (cipher_expect_q.size() == 0) begin
                    report("result beat with nothing expected", i_res_data, '0);
                end else begin
                    want = cipher_expect_q.pop_front();
                    if (i_res_data[63:0] !== want[63:0])
                        report("result_high", i_res_data, want);
                    if (i_res_data[127:64] !== want[127:64])
                        report("result_low", i_res_data, want);
                end
            end
        end
    end

    final begin
        if (cipher_expect_q.size() != 0) $display("results still owed: %0d", o_pending);
    end
endmodule

// ===== dv/tb_kuznyechik_block_cipher.sv =====
`timescale 1ns / 1ps
module tb_kuznyechik_block_cipher;
    import kuz_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 60;
    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;

    int errors, pending, checked;
    int cycles = 0;
    int sent = 0;
    int key_sets = 0;
    bit quiet = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    kuznyechik_block_cipher u_dut (.*);

    kuz_result_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .i_blk_valid(s_axis_tvalid), .i_blk_ready(s_axis_tready),
        .i_blk_data(s_axis_tdata), .i_blk_action(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, none when quiet
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 7);
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic send_block(logic act, logic [127:0] data);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_key(logic [CFG_AW-1:0] idx, logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_blocks(int count);
        logic [127:0] d;
        for (int i = 0; i < count; i++) begin
            d = {rand64(), rand64()};
            send_block(logic'($urandom_range(0, 1)), d);
        end
    endtask

    initial begin
        logic [63:0] k [4];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero key, extreme blocks both ways
        send_block(ACT_ENC, '0);
        send_block(ACT_DEC, '0);
        send_block(ACT_ENC, '1);
        send_block(ACT_DEC, '1);
        send_block(ACT_ENC, {64'h1122334455667700, 64'hffeeddccbbaa9988});
        send_block(ACT_DEC, {64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd});
        drain();

        // standard test key, plus writes past the last key index
        write_key(REG_KEY0, 64'h8899aabbccddeeff);
        write_key(REG_KEY1, 64'h0011223344556677);
        write_key(REG_KEY2, 64'hfedcba9876543210);
        write_key(REG_KEY3, 64'h0123456789abcdef);
        write_key(CFG_AW'(4), 64'hdeadbeefdeadbeef);
        write_key(CFG_AW'(7), '1);
        key_sets++;
        send_block(ACT_ENC, {64'h1122334455667700, 64'hffeeddccbbaa9988});
        send_block(ACT_DEC, {64'h7f679d90bebc2430, 64'h5a468d42b9d4edcd});
        send_block(ACT_ENC, {64'h8000000000000000, 64'h0000000000000001});
        send_block(ACT_DEC, {64'h0000000000000001, 64'h8000000000000000});
        drain();

        // all-ones key
        for (int i = 0; i < 4; i++) write_key(CFG_AW'(i), '1);
        key_sets++;
        send_block(ACT_ENC, '0);
        send_block(ACT_DEC, '1);
        random_blocks(6);
        drain();

        // random key sets, sender pauses between them for the pipe to empty
        for (int s = 0; s < 7; s++) begin
            for (int i = 0; i < 4; i++) k[i] = rand64();
            for (int i = 0; i < 4; i++) write_key(CFG_AW'(i), k[i]);
            key_sets++;
            if (s == 6) quiet = 1'b1;
            random_blocks(110);
            drain();
        end

        $display("covered %0d blocks under %0d key settings incl. zero and all-ones keys",
                 sent, key_sets + 1);
        $display("%0d results compared, stalls on both channels", checked);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== kuznyechik_block_cipher.f =====
src/kuz_pkg.sv
src/kuz_ram.sv
src/kuznyechik_block_cipher.sv
dv/kuz_result_checker.sv
dv/tb_kuznyechik_block_cipher.sv
